// ===== rtl/kplc_pkg.sv =====
// ----------------------------------------------------------------------------
// kplc_pkg
// Types, codes and helpers shared by the keypad PIN lock controller.
// ----------------------------------------------------------------------------
package kplc_pkg;

   localparam int PIN_DIGITS_DEF    = 4;
   localparam int HISTORY_DEPTH_DEF = 3;

   localparam logic [31:0] PIN_RESET_WIDE = 32'h0000_1234;
   localparam logic [3:0]  ATTEMPT_LIMIT_RESET = 4'd3;
   localparam logic [7:0]  LOCKOUT_TICKS_RESET = 8'd10;

   localparam logic [4:0] KEY_D = 5'd16;

   localparam logic [3:0] EV_NONE       = 4'd0;
   localparam logic [3:0] EV_DIGIT      = 4'd1;
   localparam logic [3:0] EV_UNLOCKED   = 4'd2;
   localparam logic [3:0] EV_WRONG      = 4'd3;
   localparam logic [3:0] EV_LOCK_START = 4'd4;
   localparam logic [3:0] EV_LOCK_END   = 4'd5;
   localparam logic [3:0] EV_RELOCKED   = 4'd6;
   localparam logic [3:0] EV_CHANGE     = 4'd7;
   localparam logic [3:0] EV_CHANGED    = 4'd8;
   localparam logic [3:0] EV_REUSED     = 4'd9;
   localparam logic [3:0] EV_BADLEN     = 4'd10;

   localparam logic [1:0] MC_LOCKED  = 2'd0;
   localparam logic [1:0] MC_MENU    = 2'd1;
   localparam logic [1:0] MC_CHANGE  = 2'd2;
   localparam logic [1:0] MC_LOCKOUT = 2'd3;

   localparam logic CSR_ATTEMPT_LIMIT = 1'b0;
   localparam logic CSR_LOCKOUT_TICKS = 1'b1;

   typedef enum logic [3:0] {
      MODE_LOCKED  = 4'b0001,
      MODE_MENU    = 4'b0010,
      MODE_CHANGE  = 4'b0100,
      MODE_LOCKOUT = 4'b1000
   } mode_type;

   typedef struct packed {
      logic       req_type;
      logic [4:0] key_code;
   } kplc_req_type;

   typedef struct packed {
      logic [3:0] event_code;
      logic [1:0] mode_now;
      logic [2:0] digits_held;
      logic [3:0] last_digit;
      logic [3:0] tries_left;
      logic [7:0] wait_left;
   } kplc_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type key_digit(input logic [4:0] key);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      case (key) inside
         [5'd1:5'd3]:  d.value = key[3:0];
         [5'd5:5'd7]:  d.value = key[3:0] - 4'd1;
         [5'd9:5'd11]: d.value = key[3:0] - 4'd2;
         5'd14:        d.value = 4'd0;
         default:      d.valid = 1'b0;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_LOCKED:  c = MC_LOCKED;
         MODE_MENU:    c = MC_MENU;
         MODE_CHANGE:  c = MC_CHANGE;
         MODE_LOCKOUT: c = MC_LOCKOUT;
         default:      c = MC_LOCKED;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/kplc_core.sv =====
// ----------------------------------------------------------------------------
// kplc_core
// Lock state, PIN store and history; one step per strobe, result combinational.
// ----------------------------------------------------------------------------
module kplc_core #(
   parameter int PIN_DIGITS    = kplc_pkg::PIN_DIGITS_DEF,
   parameter int HISTORY_DEPTH = kplc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  kplc_pkg::kplc_req_type item,
   input  logic [3:0]            attempt_limit,
   input  logic [7:0]            lockout_ticks,
   output kplc_pkg::kplc_rsp_type result
);
   import kplc_pkg::*;

   localparam int BUF_W = 4 * PIN_DIGITS;
   localparam int CNT_W = $clog2(PIN_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);

   mode_type         mode_ff, mode_in;
   logic [BUF_W-1:0] entry_buffer_ff, entry_buffer_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [3:0]       fail_count_ff, fail_count_in;
   logic [BUF_W-1:0] pin_value_ff, pin_value_in;
   logic [BUF_W-1:0] pin_history_ff [HISTORY_DEPTH];
   logic [7:0]       lockout_count_ff, lockout_count_in;

   digit_type        dig;
   logic [3:0]       fail_inc;
   logic             full;
   logic             reused;
   logic             hist_shift;
   logic [3:0]       ev;
   logic [3:0]       shown;
   logic [CNT_W+2:0] count_ext;

   always_comb begin
      reused = 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (pin_history_ff[i] == entry_buffer_ff) begin
            reused = 1'b1;
         end
      end
   end

   always_comb begin
      dig              = key_digit(item.key_code);
      fail_inc         = (fail_count_ff == 4'hF) ? fail_count_ff : fail_count_ff + 4'd1;
      full             = (entry_count_ff == CNT_FULL);
      mode_in          = mode_ff;
      entry_buffer_in  = entry_buffer_ff;
      entry_count_in   = entry_count_ff;
      fail_count_in    = fail_count_ff;
      pin_value_in     = pin_value_ff;
      lockout_count_in = lockout_count_ff;
      hist_shift       = 1'b0;
      ev               = EV_NONE;
      shown            = 4'd0;
      case (mode_ff)
         MODE_LOCKOUT: begin
            if (item.req_type) begin
               if (lockout_count_ff <= 8'd1) begin
                  lockout_count_in = 8'd0;
                  fail_count_in    = 4'd0;
                  mode_in          = MODE_LOCKED;
                  ev               = EV_LOCK_END;
               end else begin
                  lockout_count_in = lockout_count_ff - 8'd1;
               end
            end
         end
         MODE_MENU: begin
            if (!item.req_type && dig.valid) begin
               if (dig.value == 4'd1) begin
                  entry_buffer_in = '0;
                  entry_count_in  = '0;
                  mode_in         = MODE_CHANGE;
                  ev              = EV_CHANGE;
               end else if (dig.value == 4'd2) begin
                  entry_buffer_in = '0;
                  entry_count_in  = '0;
                  mode_in         = MODE_LOCKED;
                  ev              = EV_RELOCKED;
               end
            end
         end
         MODE_LOCKED, MODE_CHANGE: begin
            if (!item.req_type) begin
               if (dig.valid) begin
                  if (!full) begin
                     entry_buffer_in = (entry_buffer_ff << 4) | BUF_W'(dig.value);
                     entry_count_in  = entry_count_ff + CNT_W'(1);
                     shown           = dig.value;
                     ev              = EV_DIGIT;
                  end
               end else if (item.key_code == KEY_D) begin
                  entry_buffer_in = '0;
                  entry_count_in  = '0;
                  if (mode_ff == MODE_LOCKED) begin
                     if (full && entry_buffer_ff == pin_value_ff) begin
                        mode_in = MODE_MENU;
                        ev      = EV_UNLOCKED;
                     end else begin
                        fail_count_in = fail_inc;
                        if (fail_inc >= attempt_limit) begin
                           mode_in          = MODE_LOCKOUT;
                           lockout_count_in = lockout_ticks;
                           ev               = EV_LOCK_START;
                        end else begin
                           ev = EV_WRONG;
                        end
                     end
                  end else if (!full) begin
                     ev = EV_BADLEN;
                  end else if (reused) begin
                     ev = EV_REUSED;
                  end else begin
                     pin_value_in = entry_buffer_ff;
                     hist_shift   = 1'b1;
                     mode_in      = MODE_LOCKED;
                     ev           = EV_CHANGED;
                  end
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_comb begin
      count_ext          = {3'b000, entry_count_in};
      result.event_code  = ev;
      result.mode_now    = mode_code(mode_in);
      result.digits_held = count_ext[2:0];
      result.last_digit  = shown;
      result.tries_left  = (attempt_limit > fail_count_in) ? attempt_limit - fail_count_in :
                                                              4'd0;
      result.wait_left   = (mode_in == MODE_LOCKOUT) ? lockout_count_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_LOCKED;
         entry_buffer_ff  <= '0;
         entry_count_ff   <= '0;
         fail_count_ff    <= 4'd0;
         pin_value_ff     <= PIN_RESET_WIDE[BUF_W-1:0];
         lockout_count_ff <= 8'd0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            pin_history_ff[i] <= '0;
         end
      end else if (step_en) begin
         mode_ff          <= mode_in;
         entry_buffer_ff  <= entry_buffer_in;
         entry_count_ff   <= entry_count_in;
         fail_count_ff    <= fail_count_in;
         pin_value_ff     <= pin_value_in;
         lockout_count_ff <= lockout_count_in;
         if (hist_shift) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               pin_history_ff[i] <= pin_history_ff[i + 1];
            end
            pin_history_ff[HISTORY_DEPTH - 1] <= entry_buffer_ff;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_FULL)
      else $error("entry count beyond PIN length");

   a_lockout_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_LOCKOUT |-> lockout_count_ff == 8'd0)
      else $error("lockout counter live outside lockout");

   a_menu_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_MENU |-> entry_count_ff == '0)
      else $error("digits held while in menu");

   a_lockout_keys: assert property (@(posedge clock) disable iff (reset)
      step_en && mode_ff == MODE_LOCKOUT && !item.req_type |=>
         $stable(fail_count_ff) && mode_ff == MODE_LOCKOUT)
      else $error("key acted during lockout");

endmodule

// ===== rtl/keypad_pin_lock_controller.sv =====
// ----------------------------------------------------------------------------
// keypad_pin_lock_controller
// Keypad PIN lock: digit entry, PIN check, lockout and PIN change with history.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                          | moves
//  req      | in        | req_valid/req_ready/req_data   | key code or tick
//  rsp      | out       | rsp_valid/rsp_ready/rsp_data   | event and status
//  csr      | in        | csr_valid/csr_ready/csr_index, | register write
//           |           | csr_data                       |
//
//  rsp valid after the req transfer: the transfer loads the input register,
//  then one step of the lock logic loads the result register. One item per
//  cycle sustained while rsp_ready stays high. csr_ready is always high.
//  Reset is synchronous and restores PIN 1234, a history of all-zero PINs,
//  attempt limit 3 and lockout_ticks 10. A stalled rsp holds the result
//  register; the input register still takes an item while it is empty.
// ----------------------------------------------------------------------------
module keypad_pin_lock_controller #(
   parameter int PIN_DIGITS    = kplc_pkg::PIN_DIGITS_DEF,
   parameter int HISTORY_DEPTH = kplc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  kplc_pkg::kplc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kplc_pkg::kplc_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [7:0]             csr_data
);
   import kplc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   kplc_req_type in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   kplc_rsp_type rsp_data_ff;
   logic [3:0]   attempt_limit_ff;
   logic [7:0]   lockout_ticks_ff;
   logic         advance;
   kplc_rsp_type step_result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   kplc_core #(
      .PIN_DIGITS    (PIN_DIGITS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (in_data_ff),
      .attempt_limit (attempt_limit_ff),
      .lockout_ticks (lockout_ticks_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_limit_ff <= ATTEMPT_LIMIT_RESET;
         lockout_ticks_ff <= LOCKOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATTEMPT_LIMIT: attempt_limit_ff <= csr_data[3:0];
            CSR_LOCKOUT_TICKS: lockout_ticks_ff <= csr_data;
            default:           attempt_limit_ff <= attempt_limit_ff;
         endcase
      end
   end

   a_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_data_ff == $past(step_result))
      else $error("step did not load the result register");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending item lost while result stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed before its transfer");

endmodule
